// File: hw/rtl/lru_block_table_with_pinning_unit_defines.svh
// Assertion macros for the table's RTL, included by lbt_ctrl.
`ifndef LRU_BLOCK_TABLE_WITH_PINNING_UNIT_DEFINES_SVH
`define LRU_BLOCK_TABLE_WITH_PINNING_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define LBT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbt assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define LBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbt assertion failed");
`else
`define LBT_ASSERT_NOW(label, ante, cons)
`define LBT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/lbt_pkg.sv
package lbt_pkg;

	localparam int TABLE_ENTRIES  = 64;
	localparam int MAX_CANDIDATES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

	localparam logic [3:0] KIND_INSERT  = 4'd0;
	localparam logic [3:0] KIND_LOOKUP  = 4'd1;
	localparam logic [3:0] KIND_UPDATE  = 4'd2;
	localparam logic [3:0] KIND_REMOVE  = 4'd3;
	localparam logic [3:0] KIND_RM_SEQ  = 4'd4;
	localparam logic [3:0] KIND_PIN     = 4'd5;
	localparam logic [3:0] KIND_UNPIN   = 4'd6;
	localparam logic [3:0] KIND_CAND    = 4'd7;
	localparam logic [3:0] KIND_CLEAR   = 4'd8;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_PIN_ERR   = 2'd3;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] seq_id;
		logic [15:0] block_number;
		logic [1:0]  tier_code;
		logic [63:0] handle_value;
		logic [47:0] byte_size;
		logic [4:0]  wanted_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_seq_id;
		logic [15:0] out_block_number;
		logic [1:0]  out_tier;
		logic [63:0] out_handle;
		logic [47:0] out_size;
		logic [7:0]  out_pins;
		logic        last;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic             load;
		logic             look;
		logic             exec;
		logic             rpt_single;
		logic             rpt_none;
		logic             step;
		logic             last;
		logic [IDX_W-1:0] rank;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [3:0]       kind;
		logic             rem_empty;
		logic             pick_any;
		logic             rest_empty;
		logic [CNT_W-1:0] want_c;
	} sts_t;

endpackage

// File: hw/rtl/lru_block_table_with_pinning_unit.sv
// Fully associative LRU table of memory blocks with pin counts, 64 entries.
// Issue an operation by raising start while busy is low; the request is
// sampled on that edge and busy stays high until the last result has gone
// out. Each result appears on rsp for exactly one cycle with done high, and
// the receiver must take it then: there is no way to hold results off.
// rsp.last marks the final result of an operation. Single-result operations
// (insert, lookup, update tier, remove, pin, unpin, clear) pass through the
// match, modify and report steps before their result shows, and take no new
// operation until it has shown. Remove sequence matches, then shows one result
// per cycle, and takes the next operation once the last result has gone out.
// Candidates walk the ranks from oldest to newest, one rank per cycle.
module lru_block_table_with_pinning_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lbt_pkg::req_t req,
	output lbt_pkg::rsp_t rsp,
	output logic          done
);
	import lbt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence the operation
	lbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// hold the entries, match keys, update ranks and drive each transfer
	lbt_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);
endmodule

// File: hw/rtl/lbt_ctrl.sv
`include "lru_block_table_with_pinning_unit_defines.svh"
module lbt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lbt_pkg::sts_t sts,
	output lbt_pkg::cmd_t cmd
);
	import lbt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_RPT  = 3'd3;
	localparam logic [2:0] S_RSEQ = 3'd4;
	localparam logic [2:0] S_CAND = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] rank_q, rank_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic             cand_last;

	assign busy = (state_q != S_IDLE);
	assign cand_last = sts.rest_empty || (CNT_W'(k_q + 1'b1) == sts.want_c);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		rank_d  = rank_q;
		k_d     = k_q;
		cmd.rank = rank_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				rank_d   = IDX_W'(TABLE_ENTRIES - 1);
				k_d      = '0;
				if (sts.kind == KIND_RM_SEQ) state_d = S_RSEQ;
				else if (sts.kind == KIND_CAND) state_d = S_CAND;
				else state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RPT;
			end
			S_RPT: begin
				cmd.rpt_single = 1'b1;
				state_d        = S_IDLE;
			end
			S_RSEQ: begin
				if (sts.rem_empty) begin
					cmd.rpt_none = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.step = 1'b1;
					cmd.last = sts.rest_empty;
					if (sts.rest_empty) state_d = S_IDLE;
				end
			end
			S_CAND: begin
				if (k_q == '0 && (sts.rem_empty || sts.want_c == '0)) begin
					cmd.rpt_none = 1'b1;
					state_d      = S_IDLE;
				end else begin
					// walk ranks oldest first, one per cycle
					cmd.step = 1'b1;
					cmd.last = cand_last;
					rank_d   = rank_q - 1'b1;
					if (sts.pick_any) begin
						k_d = CNT_W'(k_q + 1'b1);
						if (cand_last) state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rank_q  <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			rank_q  <= rank_d;
			k_q     <= k_d;
		end
	end

	`LBT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`LBT_ASSERT_NEXT(a_last_idle, cmd.step && cmd.last && sts.pick_any, !busy)
	`LBT_ASSERT_NOW(a_k_bound, state_q == S_CAND, k_q < sts.want_c || k_q == '0)
endmodule

// File: hw/rtl/lbt_dpath.sv
module lbt_dpath (
	input  logic          clk,
	input  logic          arst_n,
	input  lbt_pkg::req_t req,
	input  lbt_pkg::cmd_t cmd,
	output lbt_pkg::sts_t sts,
	output lbt_pkg::rsp_t rsp,
	output logic          done
);
	import lbt_pkg::*;

	localparam int N = TABLE_ENTRIES;

	req_t             req_q;
	logic [N-1:0]     valid_q;
	logic [15:0]      seq_q  [N];
	logic [15:0]      blk_q  [N];
	logic [1:0]       tier_q [N];
	logic [7:0]       pins_q [N];
	logic [IDX_W-1:0] rank_q [N];
	logic [63:0]      handle_mem [N];
	logic [47:0]      size_mem   [N];

	logic [N-1:0]     rem_q;
	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_slot_q, free_slot_q, slot_q;
	logic [1:0]       stat_q;
	logic             zero_q;
	rsp_t             rsp_q;
	logic             done_q;

	logic [N-1:0]     key_m, seq_m, elig_m, rank_m, low_oh, pick_oh;
	logic [IDX_W-1:0] hit_slot, free_slot, pick_slot, sel_slot, rpt_slot;
	logic [IDX_W-1:0] sel_rank, pick_rank;
	logic             do_emit;
	logic             exec_ok;

	always_comb begin
		hit_slot  = '0;
		free_slot = '0;
		for (int i = N - 1; i >= 0; i--) begin
			key_m[i]  = valid_q[i] && seq_q[i] == req_q.seq_id
				&& blk_q[i] == req_q.block_number;
			seq_m[i]  = valid_q[i] && seq_q[i] == req_q.seq_id;
			elig_m[i] = valid_q[i] && tier_q[i] == req_q.tier_code && pins_q[i] == 8'd0;
			rank_m[i] = rem_q[i] && rank_q[i] == cmd.rank;
			if (key_m[i]) hit_slot = IDX_W'(i);
			if (!valid_q[i]) free_slot = IDX_W'(i);
		end
	end

	assign low_oh  = rem_q & (~rem_q + 1'b1);
	assign pick_oh = (req_q.kind == KIND_RM_SEQ) ? low_oh : rank_m;

	always_comb begin
		pick_slot = '0;
		for (int i = 0; i < N; i++)
			if (pick_oh[i]) pick_slot = pick_slot | IDX_W'(i);
	end

	assign sel_slot  = hit_q ? hit_slot_q : free_slot_q;
	assign sel_rank  = rank_q[hit_slot_q];
	assign pick_rank = rank_q[pick_slot];
	assign exec_ok   = cmd.exec && hit_q;

	assign sts.kind       = req_q.kind;
	assign sts.rem_empty  = (rem_q == '0);
	assign sts.pick_any   = (pick_oh != '0);
	assign sts.rest_empty = ((rem_q & ~pick_oh) == '0);
	assign sts.want_c     = (32'(req_q.wanted_count) > MAX_CANDIDATES)
		? CNT_W'(MAX_CANDIDATES) : CNT_W'(req_q.wanted_count);

	// request, match results and per-item status
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.look) begin
			hit_q       <= (key_m != '0);
			free_q      <= (valid_q != '1);
			hit_slot_q  <= hit_slot;
			free_slot_q <= free_slot;
			rem_q       <= (req_q.kind == KIND_RM_SEQ) ? seq_m : elig_m;
		end
		if (cmd.step) rem_q <= rem_q & ~pick_oh;
		if (cmd.exec) begin
			slot_q <= hit_slot_q;
			zero_q <= !hit_q;
			stat_q <= hit_q ? STAT_OK : STAT_NOT_FOUND;
			unique case (req_q.kind)
				KIND_INSERT: begin
					slot_q <= sel_slot;
					zero_q <= !(hit_q || free_q);
					stat_q <= (hit_q || free_q) ? STAT_OK : STAT_FULL;
				end
				KIND_PIN: if (hit_q && pins_q[hit_slot_q] == 8'hFF) stat_q <= STAT_PIN_ERR;
				KIND_UNPIN: if (hit_q && pins_q[hit_slot_q] == 8'h00) stat_q <= STAT_PIN_ERR;
				KIND_CLEAR: begin
					zero_q <= 1'b1;
					stat_q <= STAT_OK;
				end
				KIND_LOOKUP, KIND_UPDATE, KIND_REMOVE: ;
				default: begin
					zero_q <= 1'b1;
					stat_q <= STAT_NOT_FOUND;
				end
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.exec) begin
				if (req_q.kind == KIND_INSERT && (hit_q || free_q)) valid_q[sel_slot] <= 1'b1;
				if (req_q.kind == KIND_REMOVE && hit_q) valid_q[hit_slot_q] <= 1'b0;
				if (req_q.kind == KIND_CLEAR) valid_q <= '0;
			end
			if (cmd.step && req_q.kind == KIND_RM_SEQ) valid_q <= valid_q & ~pick_oh;
		end
	end

	// entry fields and ranks
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (req_q.kind == KIND_INSERT && (hit_q || free_q)) begin
				seq_q[sel_slot]      <= req_q.seq_id;
				blk_q[sel_slot]      <= req_q.block_number;
				tier_q[sel_slot]     <= req_q.tier_code;
				pins_q[sel_slot]     <= 8'd0;
				handle_mem[sel_slot] <= req_q.handle_value;
				size_mem[sel_slot]   <= req_q.byte_size;
				for (int j = 0; j < N; j++)
					if (valid_q[j] && (!hit_q || rank_q[j] < sel_rank))
						rank_q[j] <= rank_q[j] + 1'b1;
				rank_q[sel_slot] <= '0;
			end
			if (exec_ok && (req_q.kind == KIND_LOOKUP || req_q.kind == KIND_UPDATE)) begin
				for (int j = 0; j < N; j++)
					if (valid_q[j] && rank_q[j] < sel_rank)
						rank_q[j] <= rank_q[j] + 1'b1;
				rank_q[hit_slot_q] <= '0;
			end
			if (exec_ok && req_q.kind == KIND_UPDATE) begin
				tier_q[hit_slot_q]     <= req_q.tier_code;
				handle_mem[hit_slot_q] <= req_q.handle_value;
			end
			if (exec_ok && req_q.kind == KIND_REMOVE) begin
				for (int j = 0; j < N; j++)
					if (valid_q[j] && rank_q[j] > sel_rank)
						rank_q[j] <= rank_q[j] - 1'b1;
			end
			if (exec_ok && req_q.kind == KIND_PIN && pins_q[hit_slot_q] != 8'hFF)
				pins_q[hit_slot_q] <= pins_q[hit_slot_q] + 1'b1;
			if (exec_ok && req_q.kind == KIND_UNPIN && pins_q[hit_slot_q] != 8'h00)
				pins_q[hit_slot_q] <= pins_q[hit_slot_q] - 1'b1;
		end
		if (cmd.step && req_q.kind == KIND_RM_SEQ) begin
			for (int j = 0; j < N; j++)
				if (valid_q[j] && rank_q[j] > pick_rank)
					rank_q[j] <= rank_q[j] - 1'b1;
		end
	end

	assign do_emit  = cmd.rpt_single || cmd.rpt_none || (cmd.step && sts.pick_any);
	assign rpt_slot = cmd.rpt_single ? slot_q : pick_slot;

	// result register, memory read lands here
	always_ff @(posedge clk) begin
		if (do_emit) begin
			rsp_q.out_seq_id       <= seq_q[rpt_slot];
			rsp_q.out_block_number <= blk_q[rpt_slot];
			rsp_q.out_tier         <= tier_q[rpt_slot];
			rsp_q.out_handle       <= handle_mem[rpt_slot];
			rsp_q.out_size         <= size_mem[rpt_slot];
			rsp_q.out_pins         <= pins_q[rpt_slot];
			rsp_q.status           <= STAT_OK;
			rsp_q.last             <= cmd.last;
			if (cmd.rpt_single) begin
				rsp_q.status <= stat_q;
				rsp_q.last   <= 1'b1;
			end
			if (cmd.rpt_none || (cmd.rpt_single && zero_q)) begin
				rsp_q <= '0;
				rsp_q.status <= cmd.rpt_none ? STAT_NOT_FOUND : stat_q;
				rsp_q.last   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= do_emit;
	end

	assign rsp  = rsp_q;
	assign done = done_q;
endmodule
